>>> hdl/miq_pkg.sv
package miq_pkg;

  // Queue sizing: the queue is split into two circular halves.
  localparam int CAPACITY   = 1024;
  localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
  localparam int HIDX_W     = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int HCNT_W     = $clog2(HALF_DEPTH + 1);
  localparam int SUM_W      = HCNT_W + 1;
  localparam int TOT_W      = $clog2(CAPACITY + 1);
  localparam int DATA_W     = 32;

  typedef logic [HIDX_W-1:0] hidx_t;
  typedef logic [HCNT_W-1:0] hcnt_t;
  typedef logic [DATA_W-1:0] word_t;

  // Operation codes.
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_MIDDLE = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_MOVE
  } state_e;

  // One write port and one read port of a half store.
  typedef struct packed {
    logic  we;
    hidx_t waddr;
    word_t wdata;
    logic  re;
    hidx_t raddr;
  } ram_req_t;

  // One finished result word.
  typedef struct packed {
    logic [1:0] status;
    logic       has_value;
    word_t      value;
  } res_t;

  // Index plus count, folded back into the circular range.
  function automatic hidx_t wrap_add(hidx_t idx, hcnt_t cnt);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(idx) + SUM_W'(cnt);
    if (sum >= SUM_W'(HALF_DEPTH)) begin
      sum = sum - SUM_W'(HALF_DEPTH);
    end
    return hidx_t'(sum);
  endfunction

  function automatic hidx_t wrap_inc(hidx_t idx);
    return (idx == hidx_t'(HALF_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic hidx_t wrap_dec(hidx_t idx);
    return (idx == '0) ? hidx_t'(HALF_DEPTH - 1) : idx - 1'b1;
  endfunction

endpackage

>>> hdl/miq_half_ram.sv
module miq_half_ram
  import miq_pkg::*;
(
  input  logic     clk_i,
  input  ram_req_t req_i,
  output word_t    rdata_o
);

  word_t mem_q [HALF_DEPTH];
  word_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/miq_ctrl.sv
module miq_ctrl
  import miq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  word_t      value_in_i,
  input  logic       out_free_i,
  input  word_t      first_rdata_i,
  input  word_t      second_rdata_i,
  output ram_req_t   first_req_o,
  output ram_req_t   second_req_o,
  output logic       res_load_o,
  output res_t       res_o
);

  state_e state_q, state_d;

  hidx_t fh_q, fh_d, sh_q, sh_d;
  hcnt_t fc_q, fc_d, sc_q, sc_d;

  logic [1:0] pend_status_q, pend_status_d;
  logic       pend_pop_q, pend_pop_d;
  logic       pend_move_q, pend_move_d;
  hidx_t      pend_waddr_q, pend_waddr_d;

  logic             accept;
  logic [TOT_W-1:0] total;
  logic             full;
  logic             balanced;
  hidx_t            first_tail;
  hidx_t            second_tail;
  ram_req_t         first_acc_req;

  assign accept      = in_valid_i && in_ready_o;
  assign total       = TOT_W'(fc_q) + TOT_W'(sc_q);
  assign full        = (total >= TOT_W'(CAPACITY));
  assign balanced    = (fc_q == sc_q);
  assign first_tail  = wrap_add(fh_q, fc_q);
  assign second_tail = wrap_add(sh_q, sc_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs: handshake, result load and the deferred move into the first half.
  always_comb begin
    in_ready_o  = 1'b0;
    res_load_o  = 1'b0;
    first_req_o = first_acc_req;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_MOVE: begin
        res_load_o     = out_free_i;
        first_req_o.we = out_free_i && pend_move_q;
        if (out_free_i && pend_move_q) begin
          first_req_o.waddr = pend_waddr_q;
          first_req_o.wdata = second_rdata_i;
        end
      end
      default: ;
    endcase
  end

  assign res_o.status    = pend_status_q;
  assign res_o.has_value = pend_pop_q;
  assign res_o.value     = pend_pop_q ? first_rdata_i : '0;

  // Decode of an accepted word: pointer updates, immediate writes and reads.
  always_comb begin
    fh_d          = fh_q;
    fc_d          = fc_q;
    sh_d          = sh_q;
    sc_d          = sc_q;
    pend_status_d = pend_status_q;
    pend_pop_d    = pend_pop_q;
    pend_move_d   = pend_move_q;
    pend_waddr_d  = pend_waddr_q;
    first_acc_req = '0;
    second_req_o  = '0;
    if (accept) begin
      pend_status_d = STAT_OK;
      pend_pop_d    = 1'b0;
      pend_move_d   = 1'b0;
      pend_waddr_d  = first_tail;
      case (op_i)
        OP_PUSH: begin
          if (full) begin
            pend_status_d = STAT_FULL;
          end else if (balanced && (sc_q == '0)) begin
            // Empty queue: the value lands straight in the first half.
            first_acc_req.we    = 1'b1;
            first_acc_req.waddr = first_tail;
            first_acc_req.wdata = value_in_i;
            fc_d                = fc_q + 1'b1;
          end else if (balanced) begin
            // Append at the back and shift the second half's front across.
            second_req_o.we    = 1'b1;
            second_req_o.waddr = second_tail;
            second_req_o.wdata = value_in_i;
            second_req_o.re    = 1'b1;
            second_req_o.raddr = sh_q;
            sh_d               = wrap_inc(sh_q);
            fc_d               = fc_q + 1'b1;
            pend_move_d        = 1'b1;
          end else begin
            second_req_o.we    = 1'b1;
            second_req_o.waddr = second_tail;
            second_req_o.wdata = value_in_i;
            sc_d               = sc_q + 1'b1;
          end
        end
        OP_MIDDLE: begin
          if (full) begin
            pend_status_d = STAT_FULL;
          end else if (balanced) begin
            // The new value would move across at once, so append it to the first half.
            first_acc_req.we    = 1'b1;
            first_acc_req.waddr = first_tail;
            first_acc_req.wdata = value_in_i;
            fc_d                = fc_q + 1'b1;
          end else begin
            second_req_o.we    = 1'b1;
            second_req_o.waddr = wrap_dec(sh_q);
            second_req_o.wdata = value_in_i;
            sh_d               = wrap_dec(sh_q);
            sc_d               = sc_q + 1'b1;
          end
        end
        OP_POP: begin
          if (fc_q == '0) begin
            pend_status_d = STAT_EMPTY;
          end else begin
            first_acc_req.re    = 1'b1;
            first_acc_req.raddr = fh_q;
            fh_d                = wrap_inc(fh_q);
            pend_pop_d          = 1'b1;
            if (balanced) begin
              // Refill the first half from the second half's front.
              second_req_o.re    = 1'b1;
              second_req_o.raddr = sh_q;
              sh_d               = wrap_inc(sh_q);
              sc_d               = sc_q - 1'b1;
              pend_move_d        = 1'b1;
            end else begin
              fc_d = fc_q - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Control and pointer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      fh_q          <= '0;
      fc_q          <= '0;
      sh_q          <= '0;
      sc_q          <= '0;
      pend_status_q <= STAT_OK;
      pend_pop_q    <= 1'b0;
      pend_move_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      fh_q          <= fh_d;
      fc_q          <= fc_d;
      sh_q          <= sh_d;
      sc_q          <= sc_d;
      pend_status_q <= pend_status_d;
      pend_pop_q    <= pend_pop_d;
      pend_move_q   <= pend_move_d;
    end
  end

  // The move target address needs no reset.
  always_ff @(posedge clk_i) begin
    pend_waddr_q <= pend_waddr_d;
  end

endmodule

>>> hdl/middle_insert_queue.sv
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    op_i, value_in_i
// out      output     out_valid_o / out_ready_i  status_o, has_value_o, value_out_o
//
// Each word is decoded in ST_IDLE, which issues the half-store reads and writes;
// ST_MOVE then takes the registered read data and moves any entry into the
// first half. The registered read port of the stores sets this split.
// Reset clears the state, pointers, counts, pending flags and output valid flag; the stores need no clearing.
// A full output register holds the block in ST_MOVE until it drains.
module middle_insert_queue
  import miq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] value_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic               has_value_o,
  output logic signed [31:0] value_out_o
);

  ram_req_t first_req, second_req;
  word_t    first_rdata, second_rdata;
  logic     out_free;
  logic     res_load;
  res_t     res;

  logic  out_valid_q, out_valid_d;
  res_t  res_q;

  assign out_free = !out_valid_q || out_ready_i;

  miq_half_ram u_first_ram (
    .clk_i  (clk_i),
    .req_i  (first_req),
    .rdata_o(first_rdata)
  );

  miq_half_ram u_second_ram (
    .clk_i  (clk_i),
    .req_i  (second_req),
    .rdata_o(second_rdata)
  );

  miq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .value_in_i    ($unsigned(value_in_i)),
    .out_free_i    (out_free),
    .first_rdata_i (first_rdata),
    .second_rdata_i(second_rdata),
    .first_req_o   (first_req),
    .second_req_o  (second_req),
    .res_load_o    (res_load),
    .res_o         (res)
  );

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, captured when a word finishes.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = res_q.status;
  assign has_value_o = res_q.has_value;
  assign value_out_o = $signed(res_q.value);

endmodule

>>> tb/middle_insert_queue_test.sv
`timescale 1ns / 1ps

module middle_insert_queue_test;
  import miq_pkg::*;

  // The fourth selector value is unused by the block and acts as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Cycles without any accepted word or taken result before the run is declared hung.
  localparam int IDLE_LIMIT = 2000;
  // Extra cycles after the last result to catch stray output words.
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [1:0] op;
    word_t      value;
    bit         wait_drain;
  } word_req_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         op_i = OP_PUSH;
  logic signed [31:0] value_in_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic               has_value_o;
  logic signed [31:0] value_out_o;

  word_req_t pending_words[$];
  res_t      expected_results[$];
  word_t     queue_model[$];
  int        gen_depth = 0;
  int        total_words = 0;
  int        words_presented = 0;
  int        words_taken = 0;
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  bit        calm = 1'b0;

  middle_insert_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .value_in_i  (value_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .has_value_o (has_value_o),
    .value_out_o (value_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one word to the queue model and returns the result it yields.
  // The model is a plain ordered list; a middle insert lands at ceil(n/2).
  function automatic res_t apply_word(logic [1:0] op, word_t value);
    res_t r;
    r = '0;
    r.status = STAT_OK;
    case (op)
      OP_PUSH, OP_MIDDLE: begin
        if (queue_model.size() >= CAPACITY) begin
          r.status = STAT_FULL;
        end else if (op == OP_PUSH) begin
          queue_model.push_back(value);
        end else begin
          queue_model.insert((queue_model.size() + 1) / 2, value);
        end
      end
      OP_POP: begin
        if (queue_model.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.has_value = 1'b1;
          r.value = queue_model.pop_front();
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Values lean toward the extremes of the 32-bit range.
  function automatic word_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Weighted operation choice; the remainder of 100 goes to the unused selector.
  function automatic logic [1:0] pick_op(int push_w, int mid_w, int pop_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_w) return OP_PUSH;
    if (r < push_w + mid_w) return OP_MIDDLE;
    if (r < push_w + mid_w + pop_w) return OP_POP;
    return OP_UNUSED;
  endfunction

  // Queues one word for the driver and tracks the depth it will leave behind.
  task automatic add_word(logic [1:0] op, word_t value, bit drain);
    word_req_t req;
    req.op = op;
    req.value = value;
    req.wait_drain = drain;
    pending_words.push_back(req);
    if ((op == OP_PUSH || op == OP_MIDDLE) && gen_depth < CAPACITY) begin
      gen_depth++;
    end else if (op == OP_POP && gen_depth > 0) begin
      gen_depth--;
    end
  endtask

  task automatic add_mixed(int count);
    for (int i = 0; i < count; i++) begin
      add_word(pick_op(35, 30, 30), pick_value(), 1'b0);
    end
  endtask

  // Input side: present the next word once the previous one is taken.
  always @(negedge clk_i) begin : drive_words
    word_req_t req;
    if (rst_ni && !(in_valid_i && words_taken != words_presented)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0 &&
                   !(pending_words[0].wait_drain && expected_results.size() != 0)) begin
        req = pending_words.pop_front();
        op_i <= req.op;
        value_in_i <= req.value;
        in_valid_i <= 1'b1;
        words_presented <= words_presented + 1;
        send_gap <= calm ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side: random stalls, with calm stretches where it starts no new stalls.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 399) == 0) begin
        calm <= !calm;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) begin
          stall_left <= pick_gap() + 1;
        end
      end
    end
  end

  // Check results against the oldest expectation, then record new words.
  always @(posedge clk_i) begin : watch_ports
    bit   progress;
    res_t want;
    if (rst_ni) begin
      progress = 1'b0;
      if (out_valid_o && out_ready_i) begin
        progress = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result word with none expected: status %0d has_value %0d value %h",
                 status_o, has_value_o, value_out_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
          if (has_value_o !== want.has_value) begin
            $error("has_value: expected %0d, got %0d", want.has_value, has_value_o);
            mismatches++;
          end
          if (value_out_o !== want.value) begin
            $error("value_out: expected %h, got %h", want.value, value_out_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        progress = 1'b1;
        expected_results.push_back(apply_word(op_i, value_in_i));
        words_taken <= words_taken + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= progress ? 0 : idle_cycles + 1;
      end
    end
  end

  initial begin : run
    bit first;
    // Directed words: empty pop, no-op, middle insert on empty, extremes.
    add_word(OP_POP, 32'h1234_5678, 1'b0);
    add_word(OP_UNUSED, 32'hffff_ffff, 1'b0);
    add_word(OP_MIDDLE, 32'h8000_0000, 1'b0);
    add_word(OP_PUSH, 32'h7fff_ffff, 1'b0);
    add_word(OP_MIDDLE, 32'h0000_0000, 1'b0);
    add_word(OP_PUSH, 32'hffff_ffff, 1'b0);
    add_word(OP_MIDDLE, 32'h5555_5555, 1'b0);
    add_word(OP_MIDDLE, 32'haaaa_aaaa, 1'b0);
    add_word(OP_UNUSED, 32'h0000_0000, 1'b0);
    for (int i = 0; i < 7; i++) begin
      add_word(OP_POP, pick_value(), 1'b0);
    end
    add_word(OP_PUSH, 32'h0000_0001, 1'b0);
    add_word(OP_POP, 32'hffff_ffff, 1'b0);
    add_word(OP_POP, 32'h0000_0000, 1'b0);

    add_mixed(60);

    // Fill to capacity once all results have drained, bounce on the full edge, overflow.
    first = 1'b1;
    while (gen_depth < CAPACITY) begin
      add_word(pick_op(55, 44, 1), pick_value(), first);
      first = 1'b0;
    end
    for (int i = 0; i < 12; i++) begin
      add_word(pick_op(45, 40, 15), pick_value(), 1'b0);
    end
    while (gen_depth < CAPACITY) begin
      add_word(OP_PUSH, pick_value(), 1'b0);
    end
    for (int i = 0; i < 4; i++) begin
      add_word(pick_op(50, 50, 0), pick_value(), 1'b0);
    end

    // Drain part of the way back down from full.
    first = 1'b1;
    for (int i = 0; i < 60; i++) begin
      add_word(pick_op(3, 3, 92), pick_value(), first);
      first = 1'b0;
    end

    add_mixed(40);
    total_words = pending_words.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (words_taken != total_words || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
